// ===== sv/pfra_pkg.sv =====
package pfra_pkg;

  // Field widths fixed by the request and result formats.
  localparam int ADDR_W = 24;
  localparam int CNT_W  = 13;

  // Default sizing of the frame map.
  localparam int DEF_NUM_FRAMES  = 4096;
  localparam int DEF_FRAME_BYTES = 4096;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Request operations.
  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_RESERVE   = 2'd2,
    OP_UNRESERVE = 2'd3
  } op_t;

  // Type held for each page frame in the map.
  typedef enum logic [1:0] {
    FT_FREE     = 2'd0,
    FT_ALLOC    = 2'd1,
    FT_RESERVED = 2'd2
  } ftype_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] base_addr;
    logic [CNT_W-1:0]  run_frames;
  } in_req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] run_address;
    logic [CNT_W-1:0]  free_total;
    logic [CNT_W-1:0]  reserved_total;
    logic [CNT_W-1:0]  allocated_total;
  } out_rsp_t;

endpackage

// ===== sv/page_frame_run_allocator_top.sv =====
// Allocate scans the frame map and then marks the run that it found; free, reserve and
// unreserve first turn the byte address into a frame number, then walk the run frame by
// frame. A rejected allocate skips the scan; other requests rejected up front skip it
// after the divide.
// Throughput: one request at a time; the frame map scan, one frame a cycle, sets the rate.
// Reset and each configuration write run a clearing pass over every frame, busy held high.
module page_frame_run_allocator_top import pfra_pkg::*; #(
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_req_t          in_req,
  output logic             busy,
  output logic             out_valid,
  output out_rsp_t         out_rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW      = $clog2(NUM_FRAMES);
  localparam int CFG_MAX = (1 << CNT_W) - 1;
  localparam int MAXF    = (NUM_FRAMES < CFG_MAX) ? NUM_FRAMES : CFG_MAX;
  localparam int XW      = $clog2(MAXF + 1);
  localparam int FBW     = $clog2(FRAME_BYTES + 1);
  localparam int PW      = XW + FBW;
  localparam int FTW     = $bits(ftype_t);
  localparam logic [CNT_W-1:0] RST_FRAMES = CNT_W'(MAXF);
  localparam logic [AW-1:0]    LAST_FRAME = AW'(NUM_FRAMES - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  frames_r, frames_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  res_r, res_nxt;
  logic [CNT_W-1:0]  alloc_r, alloc_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;
  op_t               op_r, op_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [CNT_W-1:0]  run_len_r, run_len_nxt;
  logic [XW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [XW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [XW-1:0]     start_r, start_nxt;
  logic              status_r, status_nxt;
  logic [ADDR_W-1:0] run_addr_r, run_addr_nxt;

  logic [XW-1:0]     msize;
  logic [XW-1:0]     cfg_size;
  logic              cfg_wr;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [FTW-1:0]    ram_wdata;
  logic [FTW-1:0]    ram_rdata;
  ftype_t            ft;
  logic              issue;
  logic              scan_end;
  logic [CNT_W-1:0]  run_inc;
  logic              alloc_hit;
  logic              brk;
  logic              chg;
  ftype_t            new_ft;
  logic              last;
  logic [PW-1:0]     prod;

  // Frames the map covers: the register, clipped to the map depth.
  assign msize    = (int'(frames_r) > MAXF) ? XW'(MAXF) : XW'(frames_r);
  assign cfg_size = (int'(cfg_data) > MAXF) ? XW'(MAXF) : XW'(cfg_data);
  assign cfg_wr   = cfg_valid && cfg_ready;

  // Frame type map.
  pfra_ram #(
    .WIDTH (FTW),
    .DEPTH (NUM_FRAMES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(rd_idx_r)),
    .rdata (ram_rdata)
  );

  // Byte address to frame number.
  pfra_div #(
    .DIVISOR (FRAME_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.base_addr),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Start byte address of an allocated run.
  assign prod = PW'(start_r) * PW'(FRAME_BYTES);

  // Check of the frame whose type has just come back from the map.
  always_comb begin
    ft        = ftype_t'(ram_rdata);
    issue     = (rd_idx_r < msize);
    scan_end  = !chk_vld_r && !issue;
    run_inc   = run_len_r + CNT_W'(1);
    alloc_hit = chk_vld_r && (op_r == OP_ALLOC) && (ft == FT_FREE) && (run_inc == n_r);
    last      = (left_r == CNT_W'(1));
    brk       = 1'b0;
    chg       = 1'b0;
    new_ft    = FT_FREE;
    case (op_r)
      OP_FREE: begin
        brk = (ft != FT_ALLOC);
        chg = !brk;
      end
      OP_RESERVE: begin
        new_ft = FT_RESERVED;
        case (ft)
          FT_FREE:     chg = 1'b1;
          FT_RESERVED: chg = 1'b0;
          default:     brk = 1'b1;
        endcase
      end
      OP_UNRESERVE: begin
        brk = (ft != FT_RESERVED);
        chg = !brk;
      end
      default: begin
        brk = 1'b0;
        chg = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == LAST_FRAME) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_req.operation == OP_ALLOC) begin
            if ((in_req.run_frames == '0) || (in_req.run_frames > CNT_W'(msize))) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if ((div_quot >= ADDR_W'(msize)) || (n_r == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (op_r == OP_ALLOC) begin
          if (alloc_hit) begin
            state_nxt = ST_MARK;
          end else if (scan_end) begin
            state_nxt = ST_DONE;
          end
        end else if (chk_vld_r && (brk || last)) begin
          state_nxt = ST_DONE;
        end else if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MARK: begin
        if (last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    // A configuration write sets the map up again from scratch.
    if (cfg_wr) begin
      state_nxt = ST_CLEAR;
    end
  end

  // Datapath, map port and result.
  always_comb begin
    frames_nxt    = frames_r;
    free_nxt      = free_r;
    res_nxt       = res_r;
    alloc_nxt     = alloc_r;
    clr_idx_nxt   = clr_idx_r;
    chk_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    left_nxt      = left_r;
    run_len_nxt   = run_len_r;
    rd_idx_nxt    = rd_idx_r;
    chk_idx_nxt   = chk_idx_r;
    start_nxt     = start_r;
    status_nxt    = status_r;
    run_addr_nxt  = run_addr_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_idx_r;
    ram_wdata     = FT_RESERVED;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt       = in_req.operation;
          n_nxt        = in_req.run_frames;
          status_nxt   = STATUS_OK;
          run_addr_nxt = '0;
          run_len_nxt  = '0;
          rd_idx_nxt   = '0;
          if (in_req.operation == OP_ALLOC) begin
            if ((in_req.run_frames == '0) || (in_req.run_frames > CNT_W'(msize))) begin
              status_nxt = STATUS_FAIL;
            end
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          rd_idx_nxt = XW'(div_quot);
          left_nxt   = n_r;
          if (div_quot >= ADDR_W'(msize)) begin
            status_nxt = STATUS_FAIL;
          end
        end
      end
      ST_SCAN: begin
        // Read one frame ahead while the previous one is checked.
        if (issue) begin
          rd_idx_nxt = rd_idx_r + XW'(1);
        end
        chk_idx_nxt = rd_idx_r;
        chk_vld_nxt = issue && (state_nxt == ST_SCAN);
        if (chk_vld_r) begin
          if (op_r == OP_ALLOC) begin
            if (ft == FT_FREE) begin
              run_len_nxt = run_inc;
              if (run_len_r == '0) begin
                start_nxt = chk_idx_r;
              end
            end else begin
              run_len_nxt = '0;
            end
            // Run found: walk back over it to mark it allocated.
            if (alloc_hit) begin
              rd_idx_nxt = (run_len_r == '0) ? chk_idx_r : start_r;
              left_nxt   = n_r;
              free_nxt   = free_r - n_r;
              alloc_nxt  = alloc_r + n_r;
            end
          end else begin
            left_nxt = left_r - CNT_W'(1);
            if (brk) begin
              status_nxt = STATUS_FAIL;
            end else if (chg) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(chk_idx_r);
              ram_wdata = new_ft;
              case (op_r)
                OP_FREE: begin
                  alloc_nxt = alloc_r - CNT_W'(1);
                  free_nxt  = free_r + CNT_W'(1);
                end
                OP_RESERVE: begin
                  free_nxt = free_r - CNT_W'(1);
                  res_nxt  = res_r + CNT_W'(1);
                end
                OP_UNRESERVE: begin
                  res_nxt  = res_r - CNT_W'(1);
                  free_nxt = free_r + CNT_W'(1);
                end
                default: begin
                  free_nxt = free_r;
                end
              endcase
            end
          end
        end
        if ((op_r == OP_ALLOC) && scan_end) begin
          status_nxt = STATUS_FAIL;
        end
      end
      ST_MARK: begin
        ram_we       = 1'b1;
        ram_waddr    = AW'(rd_idx_r);
        ram_wdata    = FT_ALLOC;
        rd_idx_nxt   = rd_idx_r + XW'(1);
        left_nxt     = left_r - CNT_W'(1);
        run_addr_nxt = ADDR_W'(prod);
      end
      ST_DONE: begin
        out_valid_nxt               = 1'b1;
        out_rsp_nxt.status          = status_r;
        out_rsp_nxt.run_address     = run_addr_r;
        out_rsp_nxt.free_total      = free_r;
        out_rsp_nxt.reserved_total  = res_r;
        out_rsp_nxt.allocated_total = alloc_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    // Configuration write: all frames reserved, counts set for the new size.
    if (cfg_wr) begin
      frames_nxt  = cfg_data;
      free_nxt    = '0;
      alloc_nxt   = '0;
      res_nxt     = CNT_W'(cfg_size);
      clr_idx_nxt = '0;
      chk_vld_nxt = 1'b0;
    end
  end

  // Control state and counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      frames_r    <= RST_FRAMES;
      free_r      <= '0;
      res_r       <= RST_FRAMES;
      alloc_r     <= '0;
      clr_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frames_r    <= frames_nxt;
      free_r      <= free_nxt;
      res_r       <= res_nxt;
      alloc_r     <= alloc_nxt;
      clr_idx_r   <= clr_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and working registers.
  always_ff @(posedge clk) begin
    out_rsp_r  <= out_rsp_nxt;
    op_r       <= op_nxt;
    n_r        <= n_nxt;
    left_r     <= left_nxt;
    run_len_r  <= run_len_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    start_r    <= start_nxt;
    status_r   <= status_nxt;
    run_addr_r <= run_addr_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== sv/pfra_ram.sv =====
module pfra_ram import pfra_pkg::*; #(
  parameter int WIDTH = $bits(ftype_t),
  parameter int DEPTH = DEF_NUM_FRAMES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pfra_div.sv =====
module pfra_div import pfra_pkg::*; #(
  parameter int DIVISOR = DEF_FRAME_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output logic              done,
  output logic [ADDR_W-1:0] quotient
);

  // Scaled reciprocal, rounded up. With SH = ADDR_W + ceil(log2(DIVISOR)) the
  // rounding error stays small enough that the quotient is exact for every
  // dividend of ADDR_W bits.
  localparam int LW = $clog2(DIVISOR);
  localparam int SH = ADDR_W + LW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam int MW = ADDR_W + 2;
  localparam int PW = ADDR_W + MW;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic              done_r, done_nxt;
  logic [PW-1:0]     prod;

  // Multiply by the reciprocal; the bits above SH are the quotient.
  always_comb begin
    prod     = PW'(dividend) * PW'(RECIP_C);
    quo_nxt  = quo_r;
    done_nxt = start;
    if (start) begin
      quo_nxt = ADDR_W'(prod >> SH);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  // Quotient register.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== dv/pfra_run_checker.sv =====
`timescale 1ns / 100ps

module pfra_run_checker import pfra_pkg::*; #(
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_req_t          in_req,
  input  logic             out_valid,
  input  out_rsp_t         out_rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               mismatches,
  output int               rsp_pending
);

  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // Shadow copy of the frame map, its counts and the frame count register.
  ftype_t           frame_map [NUM_FRAMES];
  logic [CNT_W-1:0] frames_cfg;
  int unsigned      free_n;
  int unsigned      resv_n;
  int unsigned      alloc_n;
  out_rsp_t         rsp_awaited [$];
  int               err_total = 0;

  // Values of the register above the map size behave as the full map.
  function automatic int unsigned map_span();
    return (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg;
  endfunction

  // Every frame goes back to reserved, as after reset.
  function automatic void rebuild_map();
    foreach (frame_map[i]) frame_map[i] = FT_RESERVED;
    free_n  = 0;
    alloc_n = 0;
    resv_n  = map_span();
  endfunction

  // First-fit search for n consecutive free frames; marks them allocated.
  function automatic bit grab_run(int unsigned n, output int unsigned first);
    int unsigned span;
    int unsigned run;
    int unsigned base;
    span  = map_span();
    run   = 0;
    base  = 0;
    first = 0;
    if (n == 0 || n > span) return 1'b0;
    for (int unsigned i = 0; i < span; i++) begin
      if (frame_map[i] == FT_FREE) begin
        if (run == 0) base = i;
        run++;
        if (run == n) begin
          for (int unsigned k = 0; k < n; k++) frame_map[base + k] = FT_ALLOC;
          free_n  -= n;
          alloc_n += n;
          first    = base;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  // Free, reserve or unreserve a run frame by frame; stops at the first bad frame.
  function automatic bit walk_run(op_t op, logic [ADDR_W-1:0] addr, int unsigned n);
    int unsigned span;
    int unsigned idx;
    int unsigned left;
    span = map_span();
    idx  = addr / FRAME_BYTES;
    left = n;
    if (idx >= span) return 1'b0;
    while (left > 0 && idx < span) begin
      case (op)
        OP_FREE: begin
          if (frame_map[idx] != FT_ALLOC) return 1'b0;
          frame_map[idx] = FT_FREE;
          alloc_n--;
          free_n++;
        end
        OP_RESERVE: begin
          if (frame_map[idx] == FT_FREE) begin
            frame_map[idx] = FT_RESERVED;
            free_n--;
            resv_n++;
          end else if (frame_map[idx] != FT_RESERVED) begin
            return 1'b0;
          end
        end
        default: begin
          if (frame_map[idx] != FT_RESERVED) return 1'b0;
          frame_map[idx] = FT_FREE;
          resv_n--;
          free_n++;
        end
      endcase
      left--;
      idx++;
    end
    return 1'b1;
  endfunction

  // Carries out one request on the shadow map and builds the response it must give.
  function automatic out_rsp_t apply_request(in_req_t req);
    out_rsp_t          rsp;
    int unsigned       first;
    bit                ok;
    longint unsigned   byte_addr;
    rsp   = '0;
    first = 0;
    if (req.operation == OP_ALLOC) begin
      ok = grab_run(req.run_frames, first);
      if (ok) begin
        byte_addr       = first;
        byte_addr       = byte_addr * FRAME_BYTES;
        rsp.run_address = byte_addr[ADDR_W-1:0];
      end
    end else begin
      ok = walk_run(req.operation, req.base_addr, req.run_frames);
    end
    rsp.status          = ok ? STATUS_OK : STATUS_FAIL;
    rsp.free_total      = free_n[CNT_W-1:0];
    rsp.reserved_total  = resv_n[CNT_W-1:0];
    rsp.allocated_total = alloc_n[CNT_W-1:0];
    return rsp;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_total++;
    end
  endfunction

  // Responses are checked before a new request is queued, so a response in
  // the cycle a request is taken is matched against older requests only.
  always @(posedge clk) begin : watch
    out_rsp_t want;
    if (!rst_n) begin
      frames_cfg = (NUM_FRAMES > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(NUM_FRAMES);
      rebuild_map();
      rsp_awaited.delete();
    end else begin
      if (out_valid) begin
        if (rsp_awaited.size() == 0) begin
          $error("response with no request outstanding");
          err_total++;
        end else begin
          want = rsp_awaited.pop_front();
          check_field("status", want.status, out_rsp.status);
          check_field("run_address", want.run_address, out_rsp.run_address);
          check_field("free_total", want.free_total, out_rsp.free_total);
          check_field("reserved_total", want.reserved_total, out_rsp.reserved_total);
          check_field("allocated_total", want.allocated_total, out_rsp.allocated_total);
        end
      end
      if (cfg_valid && cfg_ready) begin
        frames_cfg = cfg_data;
        rebuild_map();
      end
      if (start && !busy) rsp_awaited.push_back(apply_request(in_req));
    end
    mismatches  <= err_total;
    rsp_pending <= rsp_awaited.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import pfra_pkg::*; ();

  localparam int NUM_FRAMES  = DEF_NUM_FRAMES;
  localparam int FRAME_BYTES = DEF_FRAME_BYTES;
  localparam int CYCLE_LIMIT = 6000000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  in_req_t          in_req    = '0;
  logic             busy;
  logic             out_valid;
  out_rsp_t         out_rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;
  int               mismatches;
  int               rsp_pending;
  int               cycles    = 0;
  int unsigned      span      = NUM_FRAMES;
  bit               steady    = 1'b0;

  page_frame_run_allocator_top #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pfra_run_checker #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .rsp_pending (rsp_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog for a hung block or a lost response.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one request, idling at random beforehand (38 in a hundred each time, not in a
  // steady burst), and returns at the edge where it is taken.
  task automatic send_request(in_req_t req);
    if (!steady) begin
      while ($urandom_range(0, 99) < 38) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_op(op_t op, logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] count);
    in_req_t req;
    req.operation  = op;
    req.base_addr  = addr;
    req.run_frames = count;
    send_request(req);
  endtask

  // Waits until every request has been answered and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (rsp_pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frames_in_use(logic [CNT_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span = (value > NUM_FRAMES) ? NUM_FRAMES : value;
  endtask

  // Mostly short runs near the bottom of the map so that allocated and
  // reserved frames are hit often; the rest is noise, runs past the end and zero-length runs.
  function automatic in_req_t pick_request();
    in_req_t     req;
    int unsigned roll;
    int unsigned window;
    int unsigned frame;
    roll   = $urandom_range(0, 99);
    window = (span == 0) ? 1 : ((span < 48) ? span : 48);
    frame  = $urandom_range(0, window - 1);
    if (roll < 30) req.operation = OP_UNRESERVE;
    else if (roll < 58) req.operation = OP_ALLOC;
    else if (roll < 82) req.operation = OP_FREE;
    else req.operation = OP_RESERVE;
    req.run_frames = $urandom_range(1, 6);
    req.base_addr  = ADDR_W'(frame * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      req.base_addr  = ADDR_W'($urandom);
      req.run_frames = CNT_W'($urandom);
    end else if (roll < 15 && span < NUM_FRAMES) begin
      req.base_addr = ADDR_W'($urandom_range(span, NUM_FRAMES - 1) * FRAME_BYTES);
    end else if (roll < 20) begin
      req.run_frames = '0;
    end
    return req;
  endfunction

  task automatic random_burst(int n, bit no_gaps);
    steady = no_gaps;
    repeat (n) send_request(pick_request());
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Full map after reset: every frame starts reserved.
    send_op(OP_ALLOC, 24'h000000, 13'd0);
    send_op(OP_ALLOC, 24'h000000, 13'd1);
    send_op(OP_FREE, 24'h000000, 13'd1);
    send_op(OP_UNRESERVE, 24'h000000, 13'd8);
    send_op(OP_ALLOC, 24'hFFFFFF, 13'd3);
    send_op(OP_ALLOC, 24'h000000, 13'h1FFF);
    send_op(OP_ALLOC, 24'h000000, 13'd4096);
    send_op(OP_RESERVE, 24'h003005, 13'd2);
    // Frames already reserved must not be counted twice.
    send_op(OP_RESERVE, 24'h003FFF, 13'd3);
    send_op(OP_RESERVE, 24'h000000, 13'd1);
    // Stops at the first reserved frame, the earlier ones stay freed.
    send_op(OP_FREE, 24'h000ABC, 13'd5);
    send_op(OP_UNRESERVE, 24'hFFFFFF, 13'd1);
    send_op(OP_UNRESERVE, 24'hFFA000, 13'd5);
    // The only run of six free frames ends at the last frame.
    send_op(OP_ALLOC, 24'h000000, 13'd6);
    send_op(OP_FREE, 24'hFFA000, 13'h1FFF);
    send_op(OP_UNRESERVE, 24'h000000, 13'd0);
    send_op(OP_UNRESERVE, 24'h005000, 13'd3);
    send_op(OP_RESERVE, 24'hFFF000, 13'h1FFF);
    send_op(OP_ALLOC, 24'h000000, 13'd2);
    send_op(OP_FREE, 24'h001000, 13'd1);

    write_frames_in_use(13'd64);
    random_burst(15, 1'b0);
    random_burst(25, 1'b1);
    random_burst(15, 1'b0);

    // Empty map: every request fails.
    write_frames_in_use(13'd0);
    send_op(OP_ALLOC, 24'h000000, 13'd1);
    send_op(OP_RESERVE, 24'h000000, 13'd0);
    random_burst(5, 1'b0);

    // Runs starting past the end and runs crossing it.
    write_frames_in_use(13'd16);
    send_op(OP_UNRESERVE, 24'h014000, 13'd1);
    send_op(OP_UNRESERVE, 24'h00C000, 13'd8);
    send_op(OP_ALLOC, 24'h000000, 13'd4);
    send_op(OP_ALLOC, 24'h000000, 13'd1);
    random_burst(25, 1'b0);

    write_frames_in_use(13'h1FFF);
    random_burst(12, 1'b0);

    write_frames_in_use(13'd1);
    send_op(OP_UNRESERVE, 24'h000000, 13'd1);
    send_op(OP_ALLOC, 24'h000000, 13'd1);
    random_burst(8, 1'b0);

    write_frames_in_use(13'd4096);
    random_burst(8, 1'b0);

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && rsp_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
